### rtl/core/radix_digits_to_fixed_point_macros.svh
// Assertion helpers for the radix converter.
`ifndef RADIX_DIGITS_TO_FIXED_POINT_MACROS_SVH
`define RADIX_DIGITS_TO_FIXED_POINT_MACROS_SVH

// Generic clocked check, disabled while reset is low.
`define RDFP_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on the block clock and reset.
`define RDFP_ASSERT(name, prop, msg) \
  `RDFP_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

### rtl/core/rdfp_pkg.sv
package rdfp_pkg;

  // Default store widths.
  localparam int unsigned INT_BITS_DEF  = 32;
  localparam int unsigned FRAC_BITS_DEF = 32;

  // Result field widths.
  localparam int unsigned OUT_INT_W  = 32;
  localparam int unsigned OUT_FRAC_W = 32;

  // Radix register codes; the unused code behaves as hexadecimal.
  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // Characters.
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_COMMA   = 8'h2C;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_ONE     = 8'h31;
  localparam logic [7:0] CHAR_SEVEN   = 8'h37;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  // Offsets that map a letter straight to its digit value (letter - 'A' + 10).
  localparam logic [7:0] UPPER_OFFSET = CHAR_UPPER_A - 8'd10;
  localparam logic [7:0] LOWER_OFFSET = CHAR_LOWER_A - 8'd10;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EDGE      = 3'd1,
    ST_EXTRA_SEP = 3'd2,
    ST_BAD_DIGIT = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // Bits per digit for a radix code.
  function automatic logic [2:0] digit_width(input logic [1:0] radix);
    case (radix)
      RADIX_BIN: digit_width = 3'd1;
      RADIX_OCT: digit_width = 3'd3;
      default:   digit_width = 3'd4;
    endcase
  endfunction

  // Decode one character in the given base.
  function automatic digit_t decode_digit(input logic [7:0] c, input logic [1:0] radix);
    digit_t     d;
    logic [7:0] diff;
    d    = '0;
    diff = c - CHAR_ZERO;
    case (radix)
      RADIX_BIN: begin
        d.valid = (c == CHAR_ZERO) || (c == CHAR_ONE);
        d.value = diff[3:0];
      end
      RADIX_OCT: begin
        d.valid = (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
        d.value = diff[3:0];
      end
      default: begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          d.valid = 1'b1;
          d.value = diff[3:0];
        end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
          diff    = c - UPPER_OFFSET;
          d.valid = 1'b1;
          d.value = diff[3:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
          diff    = c - LOWER_OFFSET;
          d.valid = 1'b1;
          d.value = diff[3:0];
        end
      end
    endcase
    return d;
  endfunction

  // Keep the smallest nonzero status code.
  function automatic status_e raise_status(input status_e cur, input status_e code);
    if (cur == ST_OK || code < cur) begin
      return code;
    end
    return cur;
  endfunction

endpackage

### rtl/core/radix_digits_to_fixed_point.sv
// Converts a base 2, 8 or 16 number string, one ASCII character per item, into an
// unsigned fixed-point value (INT_BITS integer bits, FRAC_BITS fraction bits) plus
// a status code. The block takes one character per clock cycle while its input is
// not stalled; the whole per-character update (digit decode, integer shift-and-OR,
// fraction place through a small barrel shifter) settles into the number registers.
// The character flagged last produces one result item in the output register on
// the following cycle, and the number state is cleared at the same time, so the
// next number may start right away. Input is stalled only while a result sits in
// the output register and the consumer is stalling it. Write the base register
// only while no number is in progress.
`include "radix_digits_to_fixed_point_macros.svh"

module radix_digits_to_fixed_point
  import rdfp_pkg::*;
#(
  parameter int unsigned INT_BITS  = INT_BITS_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // base register write
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_radix_code_i,
  // character items
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  input  logic                  last_char_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_INT_W-1:0]  int_value_o,
  output logic [OUT_FRAC_W-1:0] frac_value_o,
  output logic [2:0]            status_o
);

  localparam int unsigned POS_W = $clog2(FRAC_BITS + 1);
  localparam int unsigned EXT_W = FRAC_BITS + 4;

  logic [1:0]           radix_q;
  logic [INT_BITS-1:0]  int_acc_q, int_acc_d;
  logic [FRAC_BITS-1:0] frac_acc_q, frac_acc_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 seen_sep_q, seen_sep_d;
  logic                 first_q, first_d;
  status_e              pend_q, pend_d;

  logic                  out_valid_q;
  logic [OUT_INT_W-1:0]  out_int_q;
  logic [OUT_FRAC_W-1:0] out_frac_q;
  status_e               out_status_q;

  logic                 in_acc;
  logic                 is_sep;
  digit_t               dig;
  logic [2:0]           width;
  logic                 int_ovf;
  logic [3:0]           dig_aligned;
  logic [EXT_W-1:0]     frac_ext;
  logic [EXT_W-1:0]     frac_shift;
  logic [POS_W:0]       pos_sum;
  logic [OUT_INT_W-1:0]  res_int;
  logic [OUT_FRAC_W-1:0] res_frac;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  // Base register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_BIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_code_i;
    end
  end

  // Per-character update of the number state.
  always_comb begin
    width       = digit_width(radix_q);
    is_sep      = (char_code_i == CHAR_DOT) || (char_code_i == CHAR_COMMA);
    dig         = decode_digit(char_code_i, radix_q);
    // left-justify the digit in four bits, first fraction bit at the top
    dig_aligned = dig.value << (3'd4 - width);
    frac_ext    = {dig_aligned, {FRAC_BITS{1'b0}}};
    frac_shift  = frac_ext >> pos_q;
    pos_sum     = {1'b0, pos_q} + (POS_W + 1)'(width);

    case (width)
      3'd1:    int_ovf = int_acc_q[INT_BITS-1];
      3'd3:    int_ovf = |int_acc_q[INT_BITS-1 -: 3];
      default: int_ovf = |int_acc_q[INT_BITS-1 -: 4];
    endcase

    int_acc_d  = int_acc_q;
    frac_acc_d = frac_acc_q;
    pos_d      = pos_q;
    seen_sep_d = seen_sep_q;
    pend_d     = pend_q;

    if (is_sep) begin
      if (first_q || last_char_i) begin
        pend_d = raise_status(pend_d, ST_EDGE);
      end
      if (seen_sep_q) begin
        pend_d = raise_status(pend_d, ST_EXTRA_SEP);
      end
      seen_sep_d = 1'b1;
    end else if (!dig.valid) begin
      pend_d = raise_status(pend_d, ST_BAD_DIGIT);
    end else if (!seen_sep_q) begin
      if (int_ovf) begin
        int_acc_d = '1;
        pend_d    = raise_status(pend_d, ST_OVERFLOW);
      end else begin
        case (width)
          3'd1:    int_acc_d = {int_acc_q[INT_BITS-2:0], dig.value[0]};
          3'd3:    int_acc_d = {int_acc_q[INT_BITS-4:0], dig.value[2:0]};
          default: int_acc_d = {int_acc_q[INT_BITS-5:0], dig.value};
        endcase
      end
    end else begin
      // bits past the store fall off the low end of the shifted digit
      frac_acc_d = frac_acc_q | frac_shift[EXT_W-1:4];
      if (pos_sum > (POS_W + 1)'(FRAC_BITS)) begin
        pos_d = POS_W'(FRAC_BITS);
      end else begin
        pos_d = pos_sum[POS_W-1:0];
      end
    end
    first_d = 1'b0;
  end

  // Result values: zero on the format errors.
  always_comb begin
    res_int  = OUT_INT_W'(int_acc_d);
    res_frac = OUT_FRAC_W'(frac_acc_d);
    if (pend_d == ST_EDGE || pend_d == ST_EXTRA_SEP || pend_d == ST_BAD_DIGIT) begin
      res_int  = '0;
      res_frac = '0;
    end
  end

  // Advance number state; clear it after the last character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_acc_q  <= '0;
      frac_acc_q <= '0;
      pos_q      <= '0;
      seen_sep_q <= 1'b0;
      first_q    <= 1'b1;
      pend_q     <= ST_OK;
    end else if (in_acc) begin
      if (last_char_i) begin
        int_acc_q  <= '0;
        frac_acc_q <= '0;
        pos_q      <= '0;
        seen_sep_q <= 1'b0;
        first_q    <= 1'b1;
        pend_q     <= ST_OK;
      end else begin
        int_acc_q  <= int_acc_d;
        frac_acc_q <= frac_acc_d;
        pos_q      <= pos_d;
        seen_sep_q <= seen_sep_d;
        first_q    <= first_d;
        pend_q     <= pend_d;
      end
    end
  end

  // Output register valid: load on the last character, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && last_char_i) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc && last_char_i) begin
      out_int_q    <= res_int;
      out_frac_q   <= res_frac;
      out_status_q <= pend_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign int_value_o  = out_int_q;
  assign frac_value_o = out_frac_q;
  assign status_o     = out_status_q;

  `RDFP_ASSERT(a_last_gives_result, (in_acc && last_char_i) |=> out_valid_q, "last character gave no result")
  `RDFP_ASSERT(a_clear_after_last, (in_acc && last_char_i) |=> (first_q && !seen_sep_q && pos_q == '0 && int_acc_q == '0 && pend_q == ST_OK), "number state not cleared after last character")
  `RDFP_ASSERT(a_pos_bounded, pos_q <= POS_W'(FRAC_BITS), "fraction position past store width")
  `RDFP_ASSERT(a_error_zero, (out_valid_q && (out_status_q == ST_EDGE || out_status_q == ST_EXTRA_SEP || out_status_q == ST_BAD_DIGIT)) |-> (out_int_q == '0 && out_frac_q == '0), "format error result not zero")
  `RDFP_ASSERT(a_ovf_saturated, (out_valid_q && out_status_q == ST_OVERFLOW) |-> (out_int_q == OUT_INT_W'({INT_BITS{1'b1}})), "overflow result not saturated")

endmodule
